[src/mi4_pkg.sv]
// Shared types, term tables and index helper for the 4x4 matrix inverse.
package mi4_pkg;

   // Control word of the shared multiply-accumulate unit.
   typedef struct packed {
      logic       clear;
      logic       add;
      logic       sub;
      logic [1:0] limb;
   } mac_ctrl_type;

   localparam int TermCount = 6;

   // The six triple products of a 3x3 determinant: column picks for the
   // minor's rows 0, 1 and 2, and whether the term is subtracted.
   localparam logic [1:0] PermJ0 [TermCount] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
   localparam logic [1:0] PermJ1 [TermCount] = '{2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1};
   localparam logic [1:0] PermJ2 [TermCount] = '{2'd2, 2'd1, 2'd2, 2'd0, 2'd1, 2'd0};
   localparam logic       PermNeg [TermCount] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

   // Maps index k of a minor onto the full 4x4 index, stepping over skip.
   function automatic logic [1:0] skip_index(input logic [1:0] k, input logic [1:0] skip);
      skip_index = (k >= skip) ? k + 2'd1 : k;
   endfunction

endpackage

[src/mi4_if.sv]
// Valid/ready channel interfaces for matrix elements and inverse elements.
interface mi4_req_if #(parameter int ELEMENT_WIDTH = 32);
   logic                            valid;
   logic                            ready;
   logic signed [ELEMENT_WIDTH-1:0] element;
   logic                            last;
   modport source (output valid, element, last, input ready);
   modport sink (input valid, element, last, output ready);
endinterface

interface mi4_rsp_if #(parameter int ELEMENT_WIDTH = 32);
   logic                            valid;
   logic                            ready;
   logic signed [ELEMENT_WIDTH-1:0] inv_element;
   logic                            singular;
   logic                            saturated;
   logic                            last_out;
   modport source (output valid, inv_element, singular, saturated, last_out, input ready);
   modport sink (input valid, inv_element, singular, saturated, last_out, output ready);
endinterface

[src/mi4_mac.sv]
// Shared signed multiplier with a registered product and a wide accumulator.
module mi4_mac #(
   parameter int ELEMENT_WIDTH = 32
) (
   input  logic                              clock,
   input  mi4_pkg::mac_ctrl_type             ctrl,
   input  logic signed [ELEMENT_WIDTH:0]     op_a,
   input  logic signed [ELEMENT_WIDTH:0]     op_b,
   output logic signed [2*ELEMENT_WIDTH+1:0] prod,
   output logic signed [4*ELEMENT_WIDTH+2:0] acc
);
   import mi4_pkg::*;

   localparam int W  = ELEMENT_WIDTH;
   localparam int PW = 2 * W + 2;
   localparam int AW = 4 * W + 3;

   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [AW-1:0] acc_ff, acc_in, addend;

   always_comb begin
      prod_in = op_a * op_b;
      case (ctrl.limb)
         2'd0: begin
            addend = AW'(prod_ff);
         end
         2'd1: begin
            addend = AW'(prod_ff) << W;
         end
         2'd2: begin
            addend = AW'(prod_ff) << (2 * W);
         end
         default: begin
            addend = AW'(prod_ff) << (3 * W);
         end
      endcase
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (ctrl.add) begin
         acc_in = ctrl.sub ? acc_ff - addend : acc_ff + addend;
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign prod = prod_ff;
   assign acc  = acc_ff;

endmodule

[src/mi4_div.sv]
// Restoring divider, one quotient bit a cycle, with rounding and saturation.
module mi4_div #(
   parameter int ELEMENT_WIDTH = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       neg,
   input  logic [3*ELEMENT_WIDTH:0]   num,
   input  logic [4*ELEMENT_WIDTH+2:0] den,
   output logic                       done,
   output logic [ELEMENT_WIDTH-1:0]   quot,
   output logic                       sat
);
   import mi4_pkg::*;

   localparam int W    = ELEMENT_WIDTH;
   localparam int F    = FRACTION_BITS;
   localparam int NW   = 3 * W + 1;
   localparam int AW   = 4 * W + 3;
   localparam int QW   = W + 2;
   localparam int DW   = ((5 * W + 5) > (NW + 2 * F + 2) ? 5 * W + 5 : NW + 2 * F + 2) + 1;
   localparam int CntW = $clog2(W + 2);

   logic [DW-1:0]   rem_ff, rem_in, dsh_ff, dsh_in;
   logic [QW-1:0]   q_ff, q_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in, done_ff, done_in, neg_ff, neg_in;
   logic            ge;
   logic [W:0]      qv, lim, mag;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      ge      = rem_ff >= dsh_ff;
      if (start) begin
         // Numerator carries the half-divisor so the floor rounds to nearest.
         rem_in  = (DW'(num) << (2 * F + 1)) + DW'(den);
         dsh_in  = DW'(den) << (W + 2);
         q_in    = '0;
         cnt_in  = CntW'(W + 1);
         busy_in = 1'b1;
         neg_in  = neg;
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = rem_ff - dsh_ff;
         end
         q_in   = {q_ff[QW-2:0], ge};
         dsh_in = dsh_ff >> 1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   // A set top quotient bit means the magnitude is past any element value.
   always_comb begin
      qv   = q_ff[W:0];
      lim  = neg_ff ? ((W + 1)'(1) << (W - 1)) : (((W + 1)'(1) << (W - 1)) - 1'b1);
      sat  = q_ff[QW-1] | (qv > lim);
      mag  = sat ? lim : qv;
      quot = neg_ff ? W'(-mag) : W'(mag);
   end

   assign done = done_ff;

endmodule

[src/matrix_inverse_4x4.sv]
// Top level of the 4x4 fixed-point matrix inverse by cofactors.
//
//   Channel  Dir  Payload                                         Beat taken when
//   req      in   element, last                                   req.valid & req.ready
//   rsp      out  inv_element, singular, saturated, last_out      rsp.valid & rsp.ready
//
// Matrix element beats are taken back to back while the block is loading.
// After the beat marked last the block is busy: it forms each cofactor on the shared
// multiplier, then the determinant, then one restoring division of ELEMENT_WIDTH + 2
// steps for each of the 16 results. At the default width the divider takes the larger
// part of that busy time, the multiplier the rest.
// Reset is synchronous and only clears the sequencer, the load count, the output valid and the divider's busy flags.
// A stalled result beat holds in the output register; the sequencer waits for it to
// drain before presenting the next one, and loading resumes once the last is queued.
module matrix_inverse_4x4 #(
   parameter int ELEMENT_WIDTH = 32,
   parameter int FRACTION_BITS = 16
) (
   input logic       clock,
   input logic       reset,
   mi4_req_if.sink   req,
   mi4_rsp_if.source rsp
);
   import mi4_pkg::*;

   localparam int W  = ELEMENT_WIDTH;
   localparam int CW = 3 * W + 1;
   localparam int AW = 4 * W + 3;

   typedef enum logic [3:0] {
      S_LOAD,
      S_COF,
      S_COF_STORE,
      S_DET,
      S_CHECK,
      S_DIV_READ,
      S_DIV_START,
      S_DIV_WAIT,
      S_EMIT
   } state_type;

   state_type     state_ff, state_in;
   logic [4:0]    load_cnt_ff, load_cnt_in;
   logic [3:0]    idx_ff, idx_in;
   logic [2:0]    term_ff, term_in;
   logic [2:0]    phase_ff, phase_in;
   logic [W:0]    lo_ff, lo_in;
   logic [AW-1:0] det_abs_ff, det_abs_in;
   logic          det_neg_ff, det_neg_in;
   logic          singular_ff, singular_in;
   logic [W-1:0]  res_elem_ff, res_elem_in;
   logic          res_sat_ff, res_sat_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]  out_elem_ff, out_elem_in;
   logic          out_sing_ff, out_sing_in, out_sat_ff, out_sat_in, out_last_ff, out_last_in;

   // Matrix store and cofactor (adjugate) store, both with registered reads.
   logic [W-1:0]  mat_mem [16];
   logic [W-1:0]  ma_rd_ff, mb_rd_ff;
   logic [3:0]    ma_addr, mb_addr;
   logic [CW-1:0] cof_mem [16];
   logic [CW-1:0] cr_rd_ff;
   logic [3:0]    cr_addr;
   logic          cof_we;

   logic                  accept;
   mac_ctrl_type          mac_ctrl;
   logic signed [W:0]     op_a, op_b;
   logic signed [2*W+1:0] prod;
   logic signed [AW-1:0]  acc;
   logic [4*W-1:0]        cof_ext;

   logic          div_start, div_neg, div_done, div_sat;
   logic [CW-1:0] div_num;
   logic [W-1:0]  div_quot;

   logic [1:0] cof_r, cof_c;
   logic       term_sub;

   assign accept    = req.valid && req.ready;
   assign req.ready = (state_ff == S_LOAD);

   // Adjugate entry (r,c) is the signed minor that leaves out row c and column r.
   assign cof_r    = idx_ff[3:2];
   assign cof_c    = idx_ff[1:0];
   assign term_sub = PermNeg[term_ff] ^ cof_r[0] ^ cof_c[0];
   assign cof_ext  = {{(W - 1){cr_rd_ff[CW-1]}}, cr_rd_ff};

   always_comb begin
      ma_addr = '0;
      mb_addr = {skip_index(2'd2, cof_c), skip_index(PermJ2[term_ff], cof_r)};
      cr_addr = idx_ff;
      if (state_ff == S_COF) begin
         if (phase_ff == 3'd0) begin
            ma_addr = {skip_index(2'd1, cof_c), skip_index(PermJ1[term_ff], cof_r)};
         end else begin
            ma_addr = {skip_index(2'd0, cof_c), skip_index(PermJ0[term_ff], cof_r)};
         end
      end else if (state_ff == S_DET) begin
         // First-row element i against adjugate entry (i,0).
         ma_addr = {2'b00, idx_ff[3:2]};
         cr_addr = {idx_ff[3:2], 2'b00};
      end
   end

   // A triple product runs as x*y, then the high and low halves of it times z.
   always_comb begin
      mac_ctrl = '{clear: 1'b0, add: 1'b0, sub: 1'b0, limb: 2'd0};
      op_a     = $signed({ma_rd_ff[W-1], ma_rd_ff});
      op_b     = $signed({mb_rd_ff[W-1], mb_rd_ff});
      lo_in    = lo_ff;
      case (state_ff)
         S_LOAD, S_COF_STORE: begin
            mac_ctrl.clear = 1'b1;
         end
         S_COF: begin
            case (phase_ff)
               3'd2: begin
                  op_a  = $signed({prod[2*W-1], prod[2*W-1:W]});
                  op_b  = $signed({ma_rd_ff[W-1], ma_rd_ff});
                  lo_in = {1'b0, prod[W-1:0]};
               end
               3'd3: begin
                  op_a     = $signed(lo_ff);
                  op_b     = $signed({ma_rd_ff[W-1], ma_rd_ff});
                  mac_ctrl = '{clear: 1'b0, add: 1'b1, sub: term_sub, limb: 2'd1};
               end
               3'd4: begin
                  mac_ctrl = '{clear: 1'b0, add: 1'b1, sub: term_sub, limb: 2'd0};
               end
               default: begin
               end
            endcase
         end
         S_DET: begin
            // The cofactor is split into limbs; only the top limb is signed.
            case (idx_ff[1:0])
               2'd0: op_b = $signed({1'b0, cof_ext[W-1:0]});
               2'd1: op_b = $signed({1'b0, cof_ext[2*W-1:W]});
               2'd2: op_b = $signed({1'b0, cof_ext[3*W-1:2*W]});
               default: op_b = $signed({cof_ext[4*W-1], cof_ext[4*W-1:3*W]});
            endcase
            if (phase_ff == 3'd2) begin
               mac_ctrl = '{clear: 1'b0, add: 1'b1, sub: 1'b0, limb: idx_ff[1:0]};
            end
         end
         default: begin
         end
      endcase
   end

   mi4_mac #(
      .ELEMENT_WIDTH(ELEMENT_WIDTH)
   ) u_mac (
      .clock(clock),
      .ctrl (mac_ctrl),
      .op_a (op_a),
      .op_b (op_b),
      .prod (prod),
      .acc  (acc)
   );

   assign div_num = cr_rd_ff[CW-1] ? CW'(-cr_rd_ff) : cr_rd_ff;
   assign div_neg = cr_rd_ff[CW-1] ^ det_neg_ff;

   mi4_div #(
      .ELEMENT_WIDTH(ELEMENT_WIDTH),
      .FRACTION_BITS(FRACTION_BITS)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .neg  (div_neg),
      .num  (div_num),
      .den  (det_abs_ff),
      .done (div_done),
      .quot (div_quot),
      .sat  (div_sat)
   );

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      load_cnt_in  = load_cnt_ff;
      idx_in       = idx_ff;
      term_in      = term_ff;
      phase_in     = phase_ff;
      det_abs_in   = det_abs_ff;
      det_neg_in   = det_neg_ff;
      singular_in  = singular_ff;
      res_elem_in  = res_elem_ff;
      res_sat_in   = res_sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      out_elem_in  = out_elem_ff;
      out_sing_in  = out_sing_ff;
      out_sat_in   = out_sat_ff;
      out_last_in  = out_last_ff;
      cof_we       = 1'b0;
      div_start    = 1'b0;
      case (state_ff)
         S_LOAD: begin
            if (accept) begin
               // Beats past the sixteenth are dropped until last arrives.
               if (load_cnt_ff < 5'd16) begin
                  load_cnt_in = load_cnt_ff + 5'd1;
               end
               if (req.last) begin
                  load_cnt_in = '0;
                  idx_in      = '0;
                  term_in     = '0;
                  phase_in    = '0;
                  state_in    = S_COF;
               end
            end
         end
         S_COF: begin
            if (phase_ff == 3'd4) begin
               phase_in = '0;
               if (term_ff == 3'(TermCount - 1)) begin
                  term_in  = '0;
                  state_in = S_COF_STORE;
               end else begin
                  term_in = term_ff + 3'd1;
               end
            end else begin
               phase_in = phase_ff + 3'd1;
            end
         end
         S_COF_STORE: begin
            cof_we = 1'b1;
            idx_in = idx_ff + 4'd1;
            if (idx_ff == 4'd15) begin
               state_in = S_DET;
            end else begin
               state_in = S_COF;
            end
         end
         S_DET: begin
            if (phase_ff == 3'd2) begin
               phase_in = '0;
               idx_in   = idx_ff + 4'd1;
               if (idx_ff == 4'd15) begin
                  state_in = S_CHECK;
               end
            end else begin
               phase_in = phase_ff + 3'd1;
            end
         end
         S_CHECK: begin
            det_neg_in  = acc[AW-1];
            det_abs_in  = acc[AW-1] ? AW'(-acc) : AW'(acc);
            singular_in = (acc == '0);
            idx_in      = '0;
            state_in    = S_DIV_READ;
         end
         S_DIV_READ: begin
            if (singular_ff) begin
               res_elem_in = '0;
               res_sat_in  = 1'b0;
               state_in    = S_EMIT;
            end else begin
               state_in = S_DIV_START;
            end
         end
         S_DIV_START: begin
            div_start = 1'b1;
            state_in  = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               res_elem_in = div_quot;
               res_sat_in  = div_sat;
               state_in    = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               out_elem_in  = res_elem_ff;
               out_sing_in  = singular_ff;
               out_sat_in   = res_sat_ff;
               out_last_in  = (idx_ff == 4'd15);
               idx_in       = idx_ff + 4'd1;
               state_in     = (idx_ff == 4'd15) ? S_LOAD : S_DIV_READ;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         load_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_cnt_ff  <= load_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      term_ff     <= term_in;
      phase_ff    <= phase_in;
      lo_ff       <= lo_in;
      det_abs_ff  <= det_abs_in;
      det_neg_ff  <= det_neg_in;
      singular_ff <= singular_in;
      res_elem_ff <= res_elem_in;
      res_sat_ff  <= res_sat_in;
      out_elem_ff <= out_elem_in;
      out_sing_ff <= out_sing_in;
      out_sat_ff  <= out_sat_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (accept && load_cnt_ff < 5'd16) begin
         mat_mem[load_cnt_ff[3:0]] <= req.element;
      end
      ma_rd_ff <= mat_mem[ma_addr];
      mb_rd_ff <= mat_mem[mb_addr];
   end

   always_ff @(posedge clock) begin
      if (cof_we) begin
         cof_mem[idx_ff] <= acc[CW-1:0];
      end
      cr_rd_ff <= cof_mem[cr_addr];
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.inv_element = out_elem_ff;
   assign rsp.singular    = out_sing_ff;
   assign rsp.saturated   = out_sat_ff;
   assign rsp.last_out    = out_last_ff;

   a_load_bound: assert property (@(posedge clock) disable iff (reset)
      load_cnt_ff <= 5'd16)
      else $error("load count past sixteen");

   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready && req.last |=> state_ff == S_COF && !req.ready)
      else $error("last beat did not start the cofactor pass");

   a_no_div_singular: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV_WAIT |-> !singular_ff)
      else $error("divider used on a singular matrix");

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.singular |-> rsp.inv_element == '0 && !rsp.saturated)
      else $error("singular result beat is not zero");

endmodule
